[sv/ectp_pkg.sv]
// ----------------------------------------------------------------------------
// ectp_pkg
// Shared constants and types for the conserved-to-primitive converter.
// ----------------------------------------------------------------------------
package ectp_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned GM1_BITS      = 18;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 18;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_EQ_MODE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GM1     = 1'd1;

  // equation modes
  localparam logic [MODE_BITS-1:0] MODE_COPY     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EULER_1D = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_EULER_2D = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED   = 2'd3;

  localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_EULER_2D;
  localparam logic [GM1_BITS-1:0]  GM1_RESET  = 18'd26214;

  // per-beat control flags carried down the pipe
  typedef struct packed {
    logic copy;
    logic euler_ok;
    logic bad;
    logic neg_u;
    logic neg_v;
    logic last;
  } ctl_t;

endpackage

[sv/ectp_div.sv]
// ----------------------------------------------------------------------------
// ectp_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ectp_div #(
  parameter int unsigned NUM_BITS = 64,
  parameter int unsigned DEN_BITS = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output logic [NUM_BITS-1:0] quot_o
);

  logic [DEN_BITS-1:0] rem_q [NUM_BITS];
  logic [DEN_BITS-1:0] rem_d [NUM_BITS];
  logic [NUM_BITS-1:0] nq_q  [NUM_BITS];  // numerator bits out top, quotient in bottom
  logic [NUM_BITS-1:0] nq_d  [NUM_BITS];
  logic [DEN_BITS-1:0] den_q [NUM_BITS];
  logic [DEN_BITS-1:0] den_d [NUM_BITS];

  always_comb begin
    logic [DEN_BITS-1:0] src_rem;
    logic [NUM_BITS-1:0] src_nq;
    logic [DEN_BITS-1:0] src_den;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   sub;
    logic                fits;
    for (int k = 0; k < NUM_BITS; k++) begin
      if (k == 0) begin
        src_rem = '0;
        src_nq  = num_i;
        src_den = den_i;
      end else begin
        src_rem = rem_q[k-1];
        src_nq  = nq_q[k-1];
        src_den = den_q[k-1];
      end
      trial    = {src_rem, src_nq[NUM_BITS-1]};
      sub      = trial - {1'b0, src_den};
      fits     = trial >= {1'b0, src_den};
      rem_d[k] = fits ? sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      nq_d[k]  = {src_nq[NUM_BITS-2:0], fits};
      den_d[k] = src_den;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_BITS; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quot_o = nq_q[NUM_BITS-1];

endmodule

[sv/ectp_delay.sv]
// ----------------------------------------------------------------------------
// ectp_delay
// Stallable delay line for valid bits and side data, matched to the divider.
// ----------------------------------------------------------------------------
module ectp_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] dat_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < DEPTH; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        dat_q[k] <= dat_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[DEPTH-1];
  assign data_o  = dat_q[DEPTH-1];

endmodule

[sv/euler_cons_to_prim_top.sv]
// ----------------------------------------------------------------------------
// euler_cons_to_prim_top
// Stages A, B and C, the divider chain, then D, E and F. DIV_BITS =
// max(WORD_BITS+FRAC_BITS, 2*WORD_BITS); one quotient bit per divider stage.
// Throughput: one cell per cycle; a stalled output holds the whole pipe.
// Reset: valid bits clear, mode returns to 2D Euler and gamma-1 to 26214.
// ----------------------------------------------------------------------------
module euler_cons_to_prim_top
  import ectp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cons_valid_i,
  output logic                     cons_stall_o,
  input  logic [WORD_BITS-1:0]     cons_density_i,
  input  logic [WORD_BITS-1:0]     cons_momentum_x_i,
  input  logic [WORD_BITS-1:0]     cons_momentum_y_i,
  input  logic [WORD_BITS-1:0]     cons_energy_i,
  input  logic                     cons_last_i,
  output logic                     prim_valid_o,
  input  logic                     prim_stall_i,
  output logic [WORD_BITS-1:0]     prim_density_o,
  output logic [WORD_BITS-1:0]     prim_velocity_x_o,
  output logic [WORD_BITS-1:0]     prim_velocity_y_o,
  output logic [WORD_BITS-1:0]     prim_pressure_o,
  output logic                     bad_density_o,
  output logic                     overflow_o,
  output logic                     prim_last_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned W        = WORD_BITS;
  localparam int unsigned W2       = 2 * WORD_BITS;
  localparam int unsigned DIV_BITS = (W + FRAC_BITS > W2) ? W + FRAC_BITS : W2;
  localparam int unsigned SIDE_W   = $bits(ctl_t) + 4 * W;
  localparam int unsigned PW       = W2 + GM1_BITS;

  localparam logic [DIV_BITS-1:0] Q_POS_MAX = {{(DIV_BITS-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [DIV_BITS-1:0] Q_NEG_MAX = Q_POS_MAX + 1'b1;
  localparam logic [PW-1:0]       P_POS_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0]       P_NEG_MAX = P_POS_MAX + 1'b1;

  // ---------------- configuration
  logic [MODE_BITS-1:0] mode_q;
  logic [GM1_BITS-1:0]  gm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      gm1_q  <= GM1_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EQ_MODE: mode_q <= cfg_data_i[MODE_BITS-1:0];
        CFG_GM1:     gm1_q  <= cfg_data_i[GM1_BITS-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless a result is waiting and stalled
  logic adv;
  assign adv          = !prim_valid_o || !prim_stall_i;
  assign cons_stall_o = !adv;

  // ---------------- stage A: input register
  logic         a_valid_q;
  logic [W-1:0] a_rho_q, a_mx_q, a_my_q, a_en_q;
  logic         a_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= cons_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rho_q  <= cons_density_i;
      a_mx_q   <= cons_momentum_x_i;
      a_my_q   <= cons_momentum_y_i;
      a_en_q   <= cons_energy_i;
      a_last_q <= cons_last_i;
    end
  end

  // ---------------- stage B: flags, magnitudes, squares
  logic         euler, rho_pos;
  logic [W-1:0] my_eff, mag_x, mag_y;
  ctl_t         ctl_a;

  always_comb begin
    euler    = (mode_q == MODE_EULER_1D) || (mode_q == MODE_EULER_2D);
    rho_pos  = !a_rho_q[W-1] && (a_rho_q != '0);
    my_eff   = (mode_q == MODE_EULER_1D) ? '0 : a_my_q;
    mag_x    = a_mx_q[W-1] ? (~a_mx_q + 1'b1) : a_mx_q;
    mag_y    = my_eff[W-1] ? (~my_eff + 1'b1) : my_eff;
    ctl_a.copy     = (mode_q == MODE_COPY);
    ctl_a.euler_ok = euler && rho_pos;
    ctl_a.bad      = euler && !rho_pos;
    ctl_a.neg_u    = a_mx_q[W-1];
    ctl_a.neg_v    = my_eff[W-1];
    ctl_a.last     = a_last_q;
  end

  logic            b_valid_q;
  ctl_t            b_ctl_q;
  logic [W-1:0]    b_rho_q, b_mx_q, b_my_q, b_en_q, b_magx_q, b_magy_q;
  logic [W2-1:0]   b_sqx_q, b_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_ctl_q  <= ctl_a;
      b_rho_q  <= a_rho_q;
      b_mx_q   <= a_mx_q;
      b_my_q   <= a_my_q;
      b_en_q   <= a_en_q;
      b_magx_q <= mag_x;
      b_magy_q <= mag_y;
      b_sqx_q  <= W2'(mag_x) * W2'(mag_x);
      b_sqy_q  <= W2'(mag_y) * W2'(mag_y);
    end
  end

  // ---------------- stage C: divider operands
  logic                c_valid_q;
  ctl_t                c_ctl_q;
  logic [W-1:0]        c_rho_q, c_mx_q, c_my_q, c_en_q;
  logic [DIV_BITS-1:0] c_num_u_q, c_num_v_q, c_num_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_ctl_q   <= b_ctl_q;
      c_rho_q   <= b_rho_q;
      c_mx_q    <= b_mx_q;
      c_my_q    <= b_my_q;
      c_en_q    <= b_en_q;
      c_num_u_q <= DIV_BITS'({b_magx_q, {FRAC_BITS{1'b0}}});
      c_num_v_q <= DIV_BITS'({b_magy_q, {FRAC_BITS{1'b0}}});
      c_num_k_q <= DIV_BITS'(b_sqx_q + b_sqy_q);
    end
  end

  // ---------------- divider chain
  logic [DIV_BITS-1:0] quot_u, quot_v, quot_k;
  logic [W-1:0]        den_2rho;

  assign den_2rho = {c_rho_q[W-2:0], 1'b0};

  ectp_div #(.NUM_BITS(DIV_BITS), .DEN_BITS(W)) u_div_u (
    .clk_i(clk_i), .en_i(adv), .num_i(c_num_u_q), .den_i(c_rho_q), .quot_o(quot_u)
  );
  ectp_div #(.NUM_BITS(DIV_BITS), .DEN_BITS(W)) u_div_v (
    .clk_i(clk_i), .en_i(adv), .num_i(c_num_v_q), .den_i(c_rho_q), .quot_o(quot_v)
  );
  ectp_div #(.NUM_BITS(DIV_BITS), .DEN_BITS(W)) u_div_k (
    .clk_i(clk_i), .en_i(adv), .num_i(c_num_k_q), .den_i(den_2rho), .quot_o(quot_k)
  );

  logic              k_valid;
  logic [SIDE_W-1:0] k_side;
  ctl_t              k_ctl;
  logic [W-1:0]      k_rho, k_mx, k_my, k_en;

  ectp_delay #(.WIDTH(SIDE_W), .DEPTH(DIV_BITS)) u_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(c_valid_q),
    .data_i ({c_ctl_q, c_rho_q, c_mx_q, c_my_q, c_en_q}),
    .valid_o(k_valid),
    .data_o (k_side)
  );

  assign {k_ctl, k_rho, k_mx, k_my, k_en} = k_side;

  // ---------------- stage D: velocity clamp, energy difference
  logic                 u_sat, v_sat;
  logic [W-1:0]         u_low, v_low;
  logic signed [W2-1:0] diff;

  always_comb begin
    u_low = quot_u[W-1:0];
    v_low = quot_v[W-1:0];
    u_sat = k_ctl.neg_u ? (quot_u > Q_NEG_MAX) : (quot_u > Q_POS_MAX);
    v_sat = k_ctl.neg_v ? (quot_v > Q_NEG_MAX) : (quot_v > Q_POS_MAX);
    diff  = signed'({{W{k_en[W-1]}}, k_en}) - signed'(quot_k[W2-1:0]);
  end

  logic          d_valid_q;
  ctl_t          d_ctl_q;
  logic [W-1:0]  d_rho_q, d_mx_q, d_my_q, d_en_q, d_u_q, d_v_q;
  logic          d_ovf_q, d_neg_p_q;
  logic [W2-1:0] d_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (adv) begin
      d_valid_q <= k_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_ctl_q <= k_ctl;
      d_rho_q <= k_rho;
      d_mx_q  <= k_mx;
      d_my_q  <= k_my;
      d_en_q  <= k_en;
      if (u_sat) begin
        d_u_q <= k_ctl.neg_u ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        d_u_q <= k_ctl.neg_u ? (~u_low + 1'b1) : u_low;
      end
      if (v_sat) begin
        d_v_q <= k_ctl.neg_v ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        d_v_q <= k_ctl.neg_v ? (~v_low + 1'b1) : v_low;
      end
      d_ovf_q   <= u_sat || v_sat;
      d_neg_p_q <= diff[W2-1];
      d_mag_q   <= diff[W2-1] ? W2'(~diff + 1'b1) : W2'(diff);
    end
  end

  // ---------------- stage E: (gamma-1) partial products
  logic                  e_valid_q;
  ctl_t                  e_ctl_q;
  logic [W-1:0]          e_rho_q, e_mx_q, e_my_q, e_en_q, e_u_q, e_v_q;
  logic                  e_ovf_q, e_neg_p_q;
  logic [W+GM1_BITS-1:0] e_lo_q, e_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_ctl_q   <= d_ctl_q;
      e_rho_q   <= d_rho_q;
      e_mx_q    <= d_mx_q;
      e_my_q    <= d_my_q;
      e_en_q    <= d_en_q;
      e_u_q     <= d_u_q;
      e_v_q     <= d_v_q;
      e_ovf_q   <= d_ovf_q;
      e_neg_p_q <= d_neg_p_q;
      e_lo_q    <= (W + GM1_BITS)'(d_mag_q[W-1:0]) * (W + GM1_BITS)'(gm1_q);
      e_hi_q    <= (W + GM1_BITS)'(d_mag_q[W2-1:W]) * (W + GM1_BITS)'(gm1_q);
    end
  end

  // ---------------- stage F: pressure clamp and output register
  logic [PW-1:0] prod, shifted;
  logic [W-1:0]  p_low, p_val;
  logic          p_sat;

  always_comb begin
    prod    = {e_hi_q, {W{1'b0}}} + PW'(e_lo_q);
    shifted = prod >> FRAC_BITS;
    p_low   = shifted[W-1:0];
    p_sat   = e_neg_p_q ? (shifted > P_NEG_MAX) : (shifted > P_POS_MAX);
    if (p_sat) begin
      p_val = e_neg_p_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      p_val = e_neg_p_q ? (~p_low + 1'b1) : p_low;
    end
  end

  logic prim_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_valid_q <= 1'b0;
    end else if (adv) begin
      prim_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prim_last_o <= e_ctl_q.last;
      if (e_ctl_q.copy) begin
        prim_density_o    <= e_rho_q;
        prim_velocity_x_o <= e_mx_q;
        prim_velocity_y_o <= e_my_q;
        prim_pressure_o   <= e_en_q;
        bad_density_o     <= 1'b0;
        overflow_o        <= 1'b0;
      end else if (e_ctl_q.euler_ok) begin
        prim_density_o    <= e_rho_q;
        prim_velocity_x_o <= e_u_q;
        prim_velocity_y_o <= e_v_q;
        prim_pressure_o   <= p_val;
        bad_density_o     <= 1'b0;
        overflow_o        <= e_ovf_q || p_sat;
      end else begin
        // bad density or undefined mode
        prim_density_o    <= '0;
        prim_velocity_x_o <= '0;
        prim_velocity_y_o <= '0;
        prim_pressure_o   <= '0;
        bad_density_o     <= e_ctl_q.bad;
        overflow_o        <= 1'b0;
      end
    end
  end

  assign prim_valid_o = prim_valid_q;

endmodule

[sv/ectp_checker.sv]
// ----------------------------------------------------------------------------
// ectp_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ectp_checker
  import ectp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cons_stall_o,
  input logic                 prim_valid_o,
  input logic                 prim_stall_i,
  input logic [WORD_BITS-1:0] prim_density_o,
  input logic [WORD_BITS-1:0] prim_velocity_x_o,
  input logic [WORD_BITS-1:0] prim_velocity_y_o,
  input logic [WORD_BITS-1:0] prim_pressure_o,
  input logic                 bad_density_o,
  input logic                 overflow_o
);

  // input side only backs up when a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cons_stall_o |-> (prim_valid_o && prim_stall_i))
    else $error("input stalled without a held result");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prim_valid_o |-> !(bad_density_o && overflow_o))
    else $error("bad density and overflow together");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prim_valid_o && bad_density_o) |->
      (prim_density_o == '0) && (prim_velocity_x_o == '0) &&
      (prim_velocity_y_o == '0) && (prim_pressure_o == '0))
    else $error("bad density beat with nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prim_valid_o && prim_stall_i) |=> (prim_valid_o && $stable(prim_pressure_o)))
    else $error("stalled result changed");

endmodule

bind euler_cons_to_prim_top ectp_checker #(.WORD_BITS(WORD_BITS)) u_ectp_checker (.*);
